FILE: rtl/core/mpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min priority queue package
// Shared types and constants for the sorted-array min priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int unsigned MPQ_CAPACITY = 64;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned MODE_W       = 3;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned STATUS_W     = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_FIND   = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_CHECK  = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                      insert;
    logic                      delete;
    logic                      clear;
    logic signed [VALUE_W-1:0] value;
  } cell_cmd_t;

  // Contents of one cell as seen by its neighbors.
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
  } cell_data_t;

endpackage

FILE: rtl/core/mpq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min priority queue cell
// One slot of the sorted chain; empty slots act as positive infinity.
// ----------------------------------------------------------------------------
module mpq_cell
  import mpq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_cmd_t  cmd_i,
  input  logic       left_lt_i,
  input  cell_data_t left_i,
  input  cell_data_t right_i,
  output logic       lt_o,
  output cell_data_t data_o
);

  logic                      valid_q, valid_d;
  logic signed [VALUE_W-1:0] value_q, value_d;

  assign lt_o   = !valid_q || (cmd_i.value < value_q);
  assign data_o = '{valid: valid_q, value: value_q};

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.insert) begin
      if (left_lt_i) begin
        valid_d = left_i.valid;
        value_d = left_i.value;
      end else if (lt_o) begin
        valid_d = 1'b1;
        value_d = cmd_i.value;
      end
    end else if (cmd_i.delete) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

FILE: rtl/core/min_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min priority queue
// Bounded min priority queue of signed 32-bit values held in a sorted chain.
// ----------------------------------------------------------------------------
// Each input item carries a mode (insert, find minimum, delete minimum,
// check empty, clear) and a value. Each item gives exactly one result item
// with the minimum found or removed, the empty flag, the count and a status.
// The values sit in a chain of CAPACITY cells kept in ascending order, so
// the minimum is always in the first cell. An insert is broadcast to all
// cells and each cell decides locally whether to keep its value, take the
// new one or take its left neighbor's; a delete shifts the chain left.
// Every operation finishes in the cycle it is accepted, and the result is
// registered, so one item is taken per cycle while the result is not stalled.
// A stalled result holds the input side off until it is taken; the queue
// then accepts the next item in the same cycle the result leaves.
// Reset empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
module min_priority_queue
  import mpq_pkg::*;
#(
  parameter int unsigned CAPACITY = MPQ_CAPACITY
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [MODE_W-1:0]          mode_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [VALUE_W-1:0]  min_value_o,
  output logic                       queue_empty_o,
  output logic [COUNT_W-1:0]         item_count_o,
  output logic [STATUS_W-1:0]        status_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic                      accept;
  logic                      out_valid_q;
  logic [CNT_W-1:0]          count_q, count_d;
  logic signed [VALUE_W-1:0] min_value_q, min_value_d;
  logic                      queue_empty_q;
  logic [COUNT_W-1:0]        item_count_q;
  logic [STATUS_W-1:0]       status_q;
  status_e                   status_d;
  cell_cmd_t                 cmd;
  logic                      is_empty;
  logic                      is_full;

  cell_data_t data   [CAPACITY];
  logic       lt     [CAPACITY];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_empty   = (count_q == '0);
  assign is_full    = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    cmd         = '{insert: 1'b0, delete: 1'b0, clear: 1'b0, value: value_i};
    count_d     = count_q;
    min_value_d = '0;
    status_d    = ST_OK;
    if (accept) begin
      case (mode_e'(mode_i))
        MODE_INSERT: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            cmd.insert = 1'b1;
            count_d    = count_q + CNT_W'(1);
          end
        end
        MODE_FIND: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            min_value_d = data[0].value;
          end
        end
        MODE_DELETE: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            cmd.delete  = 1'b1;
            min_value_d = data[0].value;
            count_d     = count_q - CNT_W'(1);
          end
        end
        MODE_CLEAR: begin
          cmd.clear = 1'b1;
          count_d   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic       left_lt;
    cell_data_t left_data;
    cell_data_t right_data;

    if (i == 0) begin : g_first
      assign left_lt   = 1'b0;
      assign left_data = '{valid: 1'b0, value: '0};
    end else begin : g_inner
      assign left_lt   = lt[i-1];
      assign left_data = data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '{valid: 1'b0, value: '0};
    end else begin : g_mid
      assign right_data = data[i+1];
    end

    mpq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .left_lt_i (left_lt),
      .left_i    (left_data),
      .right_i   (right_data),
      .lt_o      (lt[i]),
      .data_o    (data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      min_value_q   <= min_value_d;
      queue_empty_q <= (count_d == '0);
      item_count_q  <= COUNT_W'(count_d);
      status_q      <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign min_value_o   = min_value_q;
  assign queue_empty_o = queue_empty_q;
  assign item_count_o  = item_count_q;
  assign status_o      = status_q;

endmodule
